[hdl/lcsb_pkg.sv]
package lcsb_pkg;

   localparam int unsigned MEM_WORDS_DEF = 65536;
   localparam int unsigned SEG_OFF_BITS  = 12;
   localparam logic [15:0] START_PC_RST  = 16'h3000;
   localparam logic [12:0] BOUND_RST     = 13'd4096;

   localparam logic [3:0] SEG_CODE = 4'h3;
   localparam logic [3:0] SEG_HEAP = 4'h1;

   localparam logic [1:0] FLT_NONE = 2'd0;
   localparam logic [1:0] FLT_CODE = 2'd1;
   localparam logic [1:0] FLT_HEAP = 2'd2;
   localparam logic [1:0] FLT_SEG  = 2'd3;

   localparam logic [2:0] CSR_CODE_BASE  = 3'd0;
   localparam logic [2:0] CSR_CODE_BOUND = 3'd1;
   localparam logic [2:0] CSR_HEAP_BASE  = 3'd2;
   localparam logic [2:0] CSR_HEAP_BOUND = 3'd3;

   localparam logic [3:0] OP_BR   = 4'h0;
   localparam logic [3:0] OP_ADD  = 4'h1;
   localparam logic [3:0] OP_LD   = 4'h2;
   localparam logic [3:0] OP_ST   = 4'h3;
   localparam logic [3:0] OP_JSR  = 4'h4;
   localparam logic [3:0] OP_AND  = 4'h5;
   localparam logic [3:0] OP_LDR  = 4'h6;
   localparam logic [3:0] OP_STR  = 4'h7;
   localparam logic [3:0] OP_NOT  = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_STI  = 4'hB;
   localparam logic [3:0] OP_JMP  = 4'hC;
   localparam logic [3:0] OP_LEA  = 4'hE;
   localparam logic [3:0] OP_TRAP = 4'hF;

   localparam logic FUNC_LOAD = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_MEM,
      ST_DATA
   } exec_state_type;

   typedef struct packed {
      logic        func;
      logic [15:0] addr;
      logic [15:0] data;
   } item_type;

   typedef struct packed {
      logic [15:0] code_org;
      logic [12:0] code_bound;
      logic [15:0] heap_org;
      logic [12:0] heap_bound;
   } seg_cfg_type;

   typedef struct packed {
      logic [1:0]  fault;
      logic        void_seg;
      logic [15:0] pa;
   } xl_type;

   function automatic xl_type xlate(logic [15:0] va, seg_cfg_type cfg);
      xl_type r;
      logic [3:0] seg;
      logic [12:0] off;
      seg = va[15:SEG_OFF_BITS];
      off = {1'b0, va[SEG_OFF_BITS-1:0]};
      r.fault = FLT_NONE;
      r.void_seg = 1'b0;
      r.pa = 16'd0;
      if (seg == SEG_CODE) begin
         if (off >= cfg.code_bound) r.fault = FLT_CODE;
         else r.pa = cfg.code_org + {3'd0, off};
      end else if (seg == SEG_HEAP) begin
         if (off >= cfg.heap_bound) r.fault = FLT_HEAP;
         else r.pa = cfg.heap_org + {3'd0, off};
      end else if (seg[3:2] == 2'b01) begin
         r.void_seg = 1'b1;
      end else begin
         r.fault = FLT_SEG;
      end
      return r;
   endfunction

   function automatic logic [2:0] flags_of(logic [15:0] v);
      if (v == 16'd0) return 3'b010;
      if (v[15]) return 3'b100;
      return 3'b001;
   endfunction

endpackage

[hdl/lcsb_ram.sv]
module lcsb_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/lcsb_front.sv]
module lcsb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lcsb_pkg::item_type in_item,
   output logic              q_valid,
   output lcsb_pkg::item_type q_item,
   input  logic              q_pop
);

   lcsb_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

endmodule

[hdl/lcsb_exec.sv]
module lcsb_exec #(
   parameter int unsigned MEM_WORDS = lcsb_pkg::MEM_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  lcsb_pkg::item_type           q_item,
   output logic                         q_pop,
   input  lcsb_pkg::seg_cfg_type        cfg,
   output logic                         ram_we,
   output logic [$clog2(MEM_WORDS)-1:0] ram_addr,
   output logic [15:0]                  ram_wdata,
   input  logic [15:0]                  ram_rdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [71:0]                  rsp_data
);

   localparam int unsigned AW = $clog2(MEM_WORDS);

   lcsb_pkg::exec_state_type state_ff, state_in;
   logic [15:0] ins_ff, ins_in, dat_ff, dat_in;
   logic        zero_ff, zero_in, second_ff, second_in;
   logic [15:0] pc_ff;
   logic [2:0]  cc_ff;
   logic        stop_ff;
   logic [15:0] regs_ff [8];
   logic        rv_ff;
   logic [71:0] rd_ff;

   logic        out_free, commit, c_wr, c_ccw, c_trap;
   logic [1:0]  c_fault;
   logic [2:0]  c_widx, c_cc;
   logic [15:0] c_wval, c_npc, c_r0;
   logic [7:0]  c_vec;

   logic [3:0]  op;
   logic [2:0]  dr, sr1;
   logic [15:0] npc, sx9, sx6, sx11, opb, ea;
   lcsb_pkg::xl_type xl_pc, xl_ea, xl_dat;

   assign out_free = !rv_ff || rsp_ready;
   assign op   = ins_ff[15:12];
   assign dr   = ins_ff[11:9];
   assign sr1  = ins_ff[8:6];
   assign npc  = pc_ff + 16'd1;
   assign sx9  = {{7{ins_ff[8]}}, ins_ff[8:0]};
   assign sx6  = {{10{ins_ff[5]}}, ins_ff[5:0]};
   assign sx11 = {{5{ins_ff[10]}}, ins_ff[10:0]};
   assign opb  = ins_ff[5] ? {{11{ins_ff[4]}}, ins_ff[4:0]} : regs_ff[ins_ff[2:0]];
   assign ea   = (op == lcsb_pkg::OP_LDR || op == lcsb_pkg::OP_STR) ?
                 regs_ff[sr1] + sx6 : npc + sx9;
   assign xl_pc  = lcsb_pkg::xlate(pc_ff, cfg);
   assign xl_ea  = lcsb_pkg::xlate(ea, cfg);
   assign xl_dat = lcsb_pkg::xlate(dat_ff, cfg);

   always_comb begin
      state_in  = state_ff;
      ins_in    = ins_ff;
      dat_in    = dat_ff;
      zero_in   = zero_ff;
      second_in = second_ff;
      commit    = 1'b0;
      c_fault   = lcsb_pkg::FLT_NONE;
      c_wr      = 1'b0;
      c_ccw     = 1'b0;
      c_trap    = 1'b0;
      c_widx    = 3'd0;
      c_wval    = 16'd0;
      c_vec     = 8'd0;
      c_npc     = pc_ff;
      ram_we    = 1'b0;
      ram_addr  = '0;
      ram_wdata = 16'd0;
      unique case (state_ff)
         lcsb_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (q_item.func == lcsb_pkg::FUNC_LOAD || stop_ff) begin
                  commit = out_free;
                  if (q_item.func == lcsb_pkg::FUNC_LOAD) begin
                     ram_we    = out_free;
                     ram_addr  = q_item.addr[AW-1:0];
                     ram_wdata = q_item.data;
                  end
               end else if (xl_pc.fault != lcsb_pkg::FLT_NONE) begin
                  commit  = out_free;
                  c_fault = xl_pc.fault;
               end else if (xl_pc.void_seg) begin
                  ins_in   = 16'd0;
                  state_in = lcsb_pkg::ST_EXEC;
               end else begin
                  ram_addr = xl_pc.pa[AW-1:0];
                  state_in = lcsb_pkg::ST_FETCH;
               end
            end
         end
         lcsb_pkg::ST_FETCH: begin
            ins_in   = ram_rdata;
            state_in = lcsb_pkg::ST_EXEC;
         end
         lcsb_pkg::ST_EXEC: begin
            c_npc = npc;
            unique case (op)
               lcsb_pkg::OP_LD, lcsb_pkg::OP_LDR, lcsb_pkg::OP_LDI,
               lcsb_pkg::OP_STI: begin
                  if (xl_ea.fault != lcsb_pkg::FLT_NONE) begin
                     commit  = out_free;
                     c_fault = xl_ea.fault;
                     c_npc   = pc_ff;
                  end else begin
                     ram_addr  = xl_ea.pa[AW-1:0];
                     zero_in   = xl_ea.void_seg;
                     second_in = 1'b0;
                     state_in  = lcsb_pkg::ST_MEM;
                  end
               end
               lcsb_pkg::OP_ST, lcsb_pkg::OP_STR: begin
                  commit = out_free;
                  if (xl_ea.fault != lcsb_pkg::FLT_NONE) begin
                     c_fault = xl_ea.fault;
                     c_npc   = pc_ff;
                  end else begin
                     ram_we    = out_free && !xl_ea.void_seg;
                     ram_addr  = xl_ea.pa[AW-1:0];
                     ram_wdata = regs_ff[dr];
                  end
               end
               lcsb_pkg::OP_BR: begin
                  commit = out_free;
                  if ((cc_ff & dr) != 3'd0) c_npc = npc + sx9;
               end
               lcsb_pkg::OP_ADD, lcsb_pkg::OP_AND: begin
                  commit = out_free;
                  c_wr   = 1'b1;
                  c_ccw  = 1'b1;
                  c_widx = dr;
                  c_wval = (op == lcsb_pkg::OP_ADD) ? regs_ff[sr1] + opb : regs_ff[sr1] & opb;
               end
               lcsb_pkg::OP_NOT: begin
                  commit = out_free;
                  c_wr   = 1'b1;
                  c_ccw  = 1'b1;
                  c_widx = dr;
                  c_wval = ~regs_ff[sr1];
               end
               lcsb_pkg::OP_LEA: begin
                  commit = out_free;
                  c_wr   = 1'b1;
                  c_ccw  = 1'b1;
                  c_widx = dr;
                  c_wval = npc + sx9;
               end
               lcsb_pkg::OP_JSR: begin
                  commit = out_free;
                  c_wr   = 1'b1;
                  c_widx = 3'd7;
                  c_wval = npc;
                  c_npc  = ins_ff[11] ? npc + sx11 : regs_ff[sr1];
               end
               lcsb_pkg::OP_JMP: begin
                  commit = out_free;
                  c_npc  = regs_ff[sr1];
               end
               lcsb_pkg::OP_TRAP: begin
                  commit = out_free;
                  c_trap = 1'b1;
                  c_vec  = ins_ff[7:0];
               end
               default: begin
                  commit = out_free;
               end
            endcase
         end
         lcsb_pkg::ST_MEM: begin
            dat_in   = zero_ff ? 16'd0 : ram_rdata;
            state_in = lcsb_pkg::ST_DATA;
         end
         lcsb_pkg::ST_DATA: begin
            c_npc = npc;
            if (op == lcsb_pkg::OP_STI) begin
               commit = out_free;
               if (xl_dat.fault != lcsb_pkg::FLT_NONE) begin
                  c_fault = xl_dat.fault;
                  c_npc   = pc_ff;
               end else begin
                  ram_we    = out_free && !xl_dat.void_seg;
                  ram_addr  = xl_dat.pa[AW-1:0];
                  ram_wdata = regs_ff[dr];
               end
            end else if (op == lcsb_pkg::OP_LDI && !second_ff) begin
               if (xl_dat.fault != lcsb_pkg::FLT_NONE) begin
                  commit  = out_free;
                  c_fault = xl_dat.fault;
                  c_npc   = pc_ff;
               end else begin
                  ram_addr  = xl_dat.pa[AW-1:0];
                  zero_in   = xl_dat.void_seg;
                  second_in = 1'b1;
                  state_in  = lcsb_pkg::ST_MEM;
               end
            end else begin
               commit = out_free;
               c_wr   = 1'b1;
               c_ccw  = 1'b1;
               c_widx = dr;
               c_wval = dat_ff;
            end
         end
         default: state_in = lcsb_pkg::ST_IDLE;
      endcase
      if (c_fault != lcsb_pkg::FLT_NONE) begin
         c_wr   = 1'b0;
         c_ccw  = 1'b0;
         c_trap = 1'b0;
         c_widx = 3'd0;
         c_wval = 16'd0;
         c_vec  = 8'd0;
      end
      if (commit) state_in = lcsb_pkg::ST_IDLE;
   end

   assign q_pop = commit;
   assign c_cc  = c_ccw ? lcsb_pkg::flags_of(c_wval) : cc_ff;
   assign c_r0  = (c_wr && c_widx == 3'd0) ? c_wval : regs_ff[0];

   always_ff @(posedge clock) begin
      ins_ff    <= ins_in;
      dat_ff    <= dat_in;
      zero_ff   <= zero_in;
      second_ff <= second_in;
      if (commit) begin
         rd_ff <= {5'd0, c_wval, c_widx, c_wr, c_r0, c_vec, c_trap,
                   (stop_ff || c_fault != lcsb_pkg::FLT_NONE), c_fault, c_cc, c_npc};
         if (c_wr) regs_ff[c_widx] <= c_wval;
      end
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcsb_pkg::ST_IDLE;
         pc_ff    <= lcsb_pkg::START_PC_RST;
         cc_ff    <= 3'd0;
         stop_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            pc_ff <= c_npc;
            cc_ff <= c_cc;
            if (c_fault != lcsb_pkg::FLT_NONE) stop_ff <= 1'b1;
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

endmodule

[hdl/lc3_core_with_segment_bounds.sv]
// LC-3 style core with code/heap segment translation. A request beat with tuser 0 writes one
// physical memory word; tuser 1 executes one instruction. Execute runs through the fetch and
// execute states for register, branch, jump, trap and store ops, adds a memory read and a data
// state for LD, LDR and STI and repeats that pair for LDI, set by the single-port memory with
// registered read (fetch plus each dependent data read); a fetch from a void segment skips the
// read and the fetch state. A fetch fault, and any execute beat once halted, is answered from
// the idle state. A two-beat queue sits between intake and execution and a response register
// at the output, so intake continues while a result waits. A fault holds the core halted until
// reset; later execute beats only report status. Memory contents are undefined until written.
module lc3_core_with_segment_bounds #(
   parameter int unsigned MEM_WORDS = lcsb_pkg::MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // load_address[15:0], load_data[31:16]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // next_pc, cond_flags, fault_code, halted, trap_taken,
                                    // trap_vector, r0_value, wrote_register,
                                    // written_index, written_value, zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MEM_WORDS);

   lcsb_pkg::seg_cfg_type cfg_ff;
   lcsb_pkg::item_type    in_item, q_item;
   logic                  q_valid, q_pop;
   logic                  ram_we;
   logic [AW-1:0]         ram_addr;
   logic [15:0]           ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_org   <= 16'd0;
         cfg_ff.code_bound <= lcsb_pkg::BOUND_RST;
         cfg_ff.heap_org   <= 16'd0;
         cfg_ff.heap_bound <= lcsb_pkg::BOUND_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            lcsb_pkg::CSR_CODE_BASE:  cfg_ff.code_org   <= csr_wdata;
            lcsb_pkg::CSR_CODE_BOUND: cfg_ff.code_bound <= csr_wdata[12:0];
            lcsb_pkg::CSR_HEAP_BASE:  cfg_ff.heap_org   <= csr_wdata;
            lcsb_pkg::CSR_HEAP_BOUND: cfg_ff.heap_bound <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   assign in_item.func = req_tuser;
   assign in_item.addr = req_tdata[15:0];
   assign in_item.data = req_tdata[31:16];

   lcsb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   lcsb_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

   lcsb_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

[hdl/lcsb_checker.sv]
module lcsb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20:19] != 2'd0) |-> rsp_tdata[21])
      else $error("fault without halted");

   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20:19] != 2'd0) |-> (!rsp_tdata[47] && !rsp_tdata[22]))
      else $error("fault beat reports a write or trap");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind lc3_core_with_segment_bounds lcsb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam logic [2:0] CSR_START_PC = 3'd4;
   localparam logic       FUNC_EXEC    = ~lcsb_pkg::FUNC_LOAD;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         EXECS_PER_PHASE = 220;

   typedef struct packed {
      logic [4:0]  pad;
      logic [15:0] wval;
      logic [2:0]  widx;
      logic        wr;
      logic [15:0] r0;
      logic [7:0]  vec;
      logic        trap;
      logic        halted;
      logic [1:0]  fault;
      logic [2:0]  cc;
      logic [15:0] pc;
   } core_status_type;

   typedef struct {
      logic            func;
      logic [15:0]     addr;
      logic [15:0]     data;
      bit              known;
      core_status_type exp;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   lc3_core_with_segment_bounds u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   logic [15:0] gpr [8];
   logic [15:0] pc_q;
   logic [2:0]  cc_q;
   bit          halted_q;
   logic [15:0] phys_mem [0:65535];
   bit          phys_valid [0:65535];
   logic [15:0] code_org_q, heap_org_q, start_pc_q;
   logic [12:0] code_bound_q, heap_bound_q;

   core_status_type pending_status [$];
   stim_row_type    plan [$];
   int  mismatches, cycle_count, exec_beats, load_beats;
   bit  no_gaps;
   logic [1:0] last_fault;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= reset || no_gaps || ($urandom_range(99) >= 6);

   always @(posedge clock) begin
      core_status_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = pending_status.pop_front();
            if (got.fault != lcsb_pkg::FLT_NONE) last_fault = got.fault;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: pc %h/%h cc %h/%h flt %h/%h halt %b/%b trap %b/%b",
                     want.pc, got.pc, want.cc, got.cc, want.fault, got.fault,
                     want.halted, got.halted, want.trap, got.trap);
                  $display("  vec %h/%h r0 %h/%h wr %b/%b idx %h/%h val %h/%h pad %h",
                     want.vec, got.vec, want.r0, got.r0, want.wr, got.wr,
                     want.widx, got.widx, want.wval, got.wval, got.pad);
               end
            end
         end
      end
   end

   function automatic logic [1:0] translate(input logic [15:0] va, output logic [15:0] pa,
                                            output bit vd);
      pa = 16'd0;
      vd = 1'b0;
      if (va[15:12] == lcsb_pkg::SEG_CODE) begin
         if ({1'b0, va[11:0]} >= code_bound_q) return lcsb_pkg::FLT_CODE;
         pa = code_org_q + {4'd0, va[11:0]};
         return lcsb_pkg::FLT_NONE;
      end
      if (va[15:12] == lcsb_pkg::SEG_HEAP) begin
         if ({1'b0, va[11:0]} >= heap_bound_q) return lcsb_pkg::FLT_HEAP;
         pa = heap_org_q + {4'd0, va[11:0]};
         return lcsb_pkg::FLT_NONE;
      end
      if (va[15:14] == 2'b01) begin
         vd = 1'b1;
         return lcsb_pkg::FLT_NONE;
      end
      return lcsb_pkg::FLT_SEG;
   endfunction

   function automatic logic [1:0] vm_read(input logic [15:0] va, output logic [15:0] val,
                                          inout bit unsafe);
      logic [15:0] pa;
      bit vd;
      logic [1:0] f;
      f = translate(va, pa, vd);
      val = 16'd0;
      if (f == lcsb_pkg::FLT_NONE && !vd) begin
         if (!phys_valid[pa]) unsafe = 1'b1;
         val = phys_mem[pa];
      end
      return f;
   endfunction

   function automatic logic [1:0] vm_write(input logic [15:0] va, input logic [15:0] val,
                                           input bit commit);
      logic [15:0] pa;
      bit vd;
      logic [1:0] f;
      f = translate(va, pa, vd);
      if (commit && f == lcsb_pkg::FLT_NONE && !vd) begin
         phys_mem[pa] = val;
         phys_valid[pa] = 1'b1;
      end
      return f;
   endfunction

   function automatic logic [2:0] nzp_of(input logic [15:0] v);
      if (v == 16'd0) return 3'b010;
      if (v[15]) return 3'b100;
      return 3'b001;
   endfunction

   // one beat through the core; commit = 0 only evaluates
   function automatic core_status_type lc3_step(input logic func, input logic [15:0] addr,
         input logic [15:0] data, input bit commit, output bit unsafe);
      core_status_type s;
      logic [15:0] ins, npc, t, a, b, wval, off9, off6;
      logic [2:0]  dr, sr1, widx, ncc;
      logic [1:0]  flt;
      logic [7:0]  vec;
      bit wr, ccw, trap, nhalt;
      unsafe = 1'b0;
      flt = lcsb_pkg::FLT_NONE; wr = 0; ccw = 0; trap = 0; vec = 0; widx = 0; wval = 0;
      npc = pc_q; ncc = cc_q; nhalt = halted_q; t = 0; ins = 0;
      if (func == lcsb_pkg::FUNC_LOAD) begin
         if (commit) begin
            phys_mem[addr] = data;
            phys_valid[addr] = 1'b1;
         end
      end else if (!halted_q) begin
         flt = vm_read(pc_q, ins, unsafe);
         npc = pc_q + 16'd1;
         dr = ins[11:9];
         sr1 = ins[8:6];
         off9 = {{7{ins[8]}}, ins[8:0]};
         off6 = {{10{ins[5]}}, ins[5:0]};
         if (flt == lcsb_pkg::FLT_NONE) begin
            case (ins[15:12])
               lcsb_pkg::OP_BR: if ((cc_q & dr) != 3'd0) npc = npc + off9;
               lcsb_pkg::OP_ADD, lcsb_pkg::OP_AND: begin
                  b = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
                  a = gpr[sr1];
                  wval = (ins[15:12] == lcsb_pkg::OP_ADD) ? a + b : a & b;
                  wr = 1; widx = dr; ccw = 1;
               end
               lcsb_pkg::OP_NOT: begin
                  wval = ~gpr[sr1]; wr = 1; widx = dr; ccw = 1;
               end
               lcsb_pkg::OP_LD: begin
                  flt = vm_read(npc + off9, wval, unsafe);
                  wr = 1; widx = dr; ccw = 1;
               end
               lcsb_pkg::OP_LDI: begin
                  flt = vm_read(npc + off9, t, unsafe);
                  if (flt == lcsb_pkg::FLT_NONE) flt = vm_read(t, wval, unsafe);
                  wr = 1; widx = dr; ccw = 1;
               end
               lcsb_pkg::OP_LDR: begin
                  flt = vm_read(gpr[sr1] + off6, wval, unsafe);
                  wr = 1; widx = dr; ccw = 1;
               end
               lcsb_pkg::OP_LEA: begin
                  wval = npc + off9; wr = 1; widx = dr; ccw = 1;
               end
               lcsb_pkg::OP_ST: flt = vm_write(npc + off9, gpr[dr], commit);
               lcsb_pkg::OP_STI: begin
                  flt = vm_read(npc + off9, t, unsafe);
                  if (flt == lcsb_pkg::FLT_NONE) flt = vm_write(t, gpr[dr], commit);
               end
               lcsb_pkg::OP_STR: flt = vm_write(gpr[sr1] + off6, gpr[dr], commit);
               lcsb_pkg::OP_JSR: begin
                  t = ins[11] ? npc + {{5{ins[10]}}, ins[10:0]} : gpr[sr1];
                  wr = 1; widx = 3'd7; wval = npc;
                  npc = t;
               end
               lcsb_pkg::OP_JMP: npc = gpr[sr1];
               lcsb_pkg::OP_TRAP: begin
                  trap = 1; vec = ins[7:0];
               end
               default: ;
            endcase
         end
         if (flt != lcsb_pkg::FLT_NONE) begin
            nhalt = 1; trap = 0; vec = 0; wr = 0; widx = 0; wval = 0; ccw = 0;
            npc = pc_q;
         end else if (ccw) begin
            ncc = nzp_of(wval);
         end
      end
      s = '0;
      s.pc = npc;
      s.cc = ncc;
      s.fault = flt;
      s.halted = nhalt;
      s.trap = trap;
      s.vec = vec;
      s.r0 = (wr && widx == 3'd0) ? wval : gpr[0];
      s.wr = wr;
      s.widx = widx;
      s.wval = wval;
      if (commit) begin
         if (wr) gpr[widx] = wval;
         pc_q = npc;
         cc_q = ncc;
         halted_q = nhalt;
      end
      return s;
   endfunction

   function automatic logic [15:0] rand_ins();
      logic [15:0] ins;
      ins = 16'($urandom);
      if ($urandom_range(4) != 0) begin
         case (ins[15:12])
            lcsb_pkg::OP_BR, lcsb_pkg::OP_LD, lcsb_pkg::OP_ST, lcsb_pkg::OP_LDI,
            lcsb_pkg::OP_STI, lcsb_pkg::OP_LEA:
               ins[8:0] = 9'($urandom_range(16) - 8);
            lcsb_pkg::OP_JSR: if (ins[11]) ins[10:0] = 11'($urandom_range(16) - 8);
            default: ;
         endcase
      end
      return ins;
   endfunction

   task automatic push_beat(input logic f, input logic [15:0] addr, input logic [15:0] data,
                            input bit known, input core_status_type typed);
      core_status_type p;
      bit u;
      if (!no_gaps && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = lc3_step(f, addr, data, 1'b1, u);
      pending_status.push_back(known ? typed : p);
      if (f == lcsb_pkg::FUNC_LOAD) load_beats++;
      else exec_beats++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         lcsb_pkg::CSR_CODE_BASE:  code_org_q   = val;
         lcsb_pkg::CSR_CODE_BOUND: code_bound_q = val[12:0];
         lcsb_pkg::CSR_HEAP_BASE:  heap_org_q   = val;
         lcsb_pkg::CSR_HEAP_BOUND: heap_bound_q = val[12:0];
         CSR_START_PC:             start_pc_q   = val;
         default: ;
      endcase
   endtask

   // bounds are raised if needed so the current pc stays fetchable
   task automatic apply_config(input logic [15:0] cb, input logic [12:0] cbd,
         input logic [15:0] hb, input logic [12:0] hbd, input logic [15:0] sp);
      if (pc_q[15:12] == lcsb_pkg::SEG_CODE && cbd <= {1'b0, pc_q[11:0]})
         cbd = pc_q[11:0] + 13'd1;
      if (pc_q[15:12] == lcsb_pkg::SEG_HEAP && hbd <= {1'b0, pc_q[11:0]})
         hbd = pc_q[11:0] + 13'd1;
      cfg_write(lcsb_pkg::CSR_CODE_BASE, cb);
      cfg_write(lcsb_pkg::CSR_CODE_BOUND, {3'd0, cbd});
      cfg_write(lcsb_pkg::CSR_HEAP_BASE, hb);
      cfg_write(lcsb_pkg::CSR_HEAP_BOUND, {3'd0, hbd});
      cfg_write(CSR_START_PC, sp);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic data_load();
      logic [15:0] pa;
      int pick;
      pick = $urandom_range(9);
      pa = 16'($urandom);
      if (pick < 4 && code_bound_q != 0)
         pa = code_org_q + 16'($urandom_range(code_bound_q - 1));
      else if (pick < 8 && heap_bound_q != 0)
         pa = heap_org_q + 16'($urandom_range(heap_bound_q - 1));
      push_beat(lcsb_pkg::FUNC_LOAD, pa, 16'($urandom), 1'b0, '0);
   endtask

   // plant an instruction at pc if it maps to memory, then execute it
   task automatic exec_random(input logic [1:0] want);
      logic [15:0] pa, ins, tp, saved;
      bit vd, vd2, u, ok, saved_v;
      core_status_type r;
      int tries;
      ok = 1'b0;
      ins = 16'd0;
      if (!halted_q && translate(pc_q, pa, vd) == lcsb_pkg::FLT_NONE && !vd) begin
         for (tries = 0; tries < 4000 && !ok; tries++) begin
            ins = rand_ins();
            saved = phys_mem[pa];
            saved_v = phys_valid[pa];
            phys_mem[pa] = ins;
            phys_valid[pa] = 1'b1;
            r = lc3_step(FUNC_EXEC, 16'd0, 16'd0, 1'b0, u);
            phys_mem[pa] = saved;
            phys_valid[pa] = saved_v;
            if (want == lcsb_pkg::FLT_NONE)
               ok = !u && r.fault == lcsb_pkg::FLT_NONE &&
                    translate(r.pc, tp, vd2) == lcsb_pkg::FLT_NONE && !vd2;
            else
               ok = !u && r.fault == want;
         end
         if (!ok) ins = 16'd0;
         push_beat(lcsb_pkg::FUNC_LOAD, pa, ins, 1'b0, '0);
      end
      push_beat(FUNC_EXEC, 16'($urandom), 16'($urandom), 1'b0, '0);
   endtask

   task automatic add_row(input logic f, input logic [15:0] a, input logic [15:0] d,
                          input bit known, input core_status_type e);
      stim_row_type row;
      row.func = f; row.addr = a; row.data = d; row.known = known; row.exp = e;
      plan.push_back(row);
   endtask

   initial begin
      int p;
      logic [1:0] want;
      clock = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      no_gaps = 1'b0;
      last_fault = lcsb_pkg::FLT_NONE;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (phys_valid[i]) phys_valid[i] = 1'b0;
      code_org_q = 0; code_bound_q = lcsb_pkg::BOUND_RST;
      heap_org_q = 0; heap_bound_q = lcsb_pkg::BOUND_RST;
      start_pc_q = lcsb_pkg::START_PC_RST;
      pc_q = lcsb_pkg::START_PC_RST; cc_q = 3'd0; halted_q = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed program at pc 3000, code segment at physical 0
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0000, 16'h1030, 1,  // ADD R0,R0,#-16
              '{pc: 16'h3000, default: '0});
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 1,
              '{pc: 16'h3001, cc: 3'b100, r0: 16'hFFF0, wr: 1'b1, wval: 16'hFFF0, default: '0});
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0001, 16'h122F, 0, '0);  // ADD R1,R0,#15
      add_row(FUNC_EXEC, 16'hFFFF, 16'hFFFF, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0002, 16'h5460, 0, '0);  // AND R2,R1,#0
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 1,
              '{pc: 16'h3003, cc: 3'b010, r0: 16'hFFF0, wr: 1'b1, widx: 3'd2, default: '0});
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0003, 16'h96BF, 0, '0);  // NOT R3,R2
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0004, 16'hE8FF, 0, '0);  // LEA R4, max offset
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0005, 16'h3601, 0, '0);  // ST R3 -> 3007
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0006, 16'h2A00, 0, '0);  // LD R5 <- 3007
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 1,       // stored word runs as TRAP xFF
              '{pc: 16'h3008, cc: 3'b100, r0: 16'hFFF0, trap: 1'b1, vec: 8'hFF, default: '0});
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0008, 16'h4BFF, 0, '0);  // JSR max offset
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0408, 16'hC1C0, 0, '0);  // JMP R7
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h0009, 16'h8000, 0, '0);  // RTI
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h000A, 16'hD000, 0, '0);  // reserved
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      add_row(lcsb_pkg::FUNC_LOAD, 16'h000B, 16'h01FF, 0, '0);  // BR, no condition bits
      add_row(FUNC_EXEC, 16'h0000, 16'h0000, 0, '0);
      foreach (plan[i])
         push_beat(plan[i].func, plan[i].addr, plan[i].data, plan[i].known, plan[i].exp);

      for (p = 0; p < 4; p++) begin
         drain();
         no_gaps = (p == 2);
         case (p)
            0: apply_config(16'h0000, 13'd4096, 16'h0000, 13'd4096, 16'h0000);
            1: apply_config(16'hFFF0, 13'($urandom_range(1, 4096)), 16'($urandom), 13'd0,
                            16'hFFFF);
            2: apply_config(16'($urandom), 13'($urandom_range(4096)), 16'($urandom),
                            13'($urandom_range(4096)), 16'($urandom));
            default: apply_config(16'($urandom), 13'd4096, 16'hFFFF, 13'd4096, 16'($urandom));
         endcase
         repeat (EXECS_PER_PHASE) begin
            if ($urandom_range(3) == 0) data_load();
            exec_random(lcsb_pkg::FLT_NONE);
         end
      end

      // tight bounds, then one deliberate fault; the core stays halted afterwards
      drain();
      no_gaps = 1'b0;
      apply_config(16'($urandom), 13'($urandom_range(64)), 16'($urandom),
                   13'($urandom_range(64)), 16'($urandom));
      want = 2'($urandom_range(1, 3));
      exec_random(want);
      repeat (4) begin
         data_load();
         push_beat(FUNC_EXEC, 16'($urandom), 16'($urandom), 1'b0, '0);
      end
      drain();

      $display("%0d execute and %0d memory beats over 5 segment settings",
               exec_beats, load_beats);
      $display("fault code seen last: %0d, core halted: %0b", last_fault, halted_q);
      if (mismatches == 0 && pending_status.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
